// ===== src/bcd_up_down_digit_counter_defines.svh =====
// assertion macros shared by the rtl
`ifndef BCD_UP_DOWN_DIGIT_COUNTER_DEFINES_SVH
`define BCD_UP_DOWN_DIGIT_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BCDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BCDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bcdc_pkg.sv =====
package bcdc_pkg;

  localparam logic signed [15:0] CAPACITY_MAX = 16'sd9999;
  localparam logic [13:0]        LIMIT_RESET  = 14'd9999;

  // register index decoded from paddr[2]
  localparam logic REG_COUNT_LIMIT = 1'b0;

  // digit positions
  localparam logic [1:0] POS_UNITS     = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  // operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_STEP
  } bcdc_fsm_t;

  // counter state: digit[0] units .. digit[3] thousands, plus binary count
  typedef struct packed {
    logic [3:0][3:0]    digit;
    logic signed [15:0] count;
  } bcdc_ctr_t;

  function automatic logic [9:0] weight_of(input logic [1:0] pos);
    logic [9:0] w;
    unique case (pos)
      POS_UNITS:     w = 10'd1;
      POS_TENS:      w = 10'd10;
      POS_HUNDREDS:  w = 10'd100;
      POS_THOUSANDS: w = 10'd1000;
      default:       w = 10'd1;
    endcase
    return w;
  endfunction

endpackage

// ===== src/bcd_up_down_digit_counter.sv =====
// Four-digit BCD up/down counter with a signed 16-bit binary shadow count.
// An input word either clears the counter or applies "amount" unit steps at
// one digit position (units, tens, hundreds, thousands), adding or
// subtracting; each step saturates the count at the 16-bit signed bounds,
// carries or borrows through the digits, skips the thousands bump once the
// count passes 9999 and skips the digit borrow while the count is negative.
// The thousands digit wraps modulo 16. Every input word yields exactly one
// output word holding the digits, the count and the over_limit,
// over_capacity and below_zero flags. A single step unit applies one unit
// step per clock: a word is accepted, then each of its unit steps is
// applied (none for a clear or a zero amount), then the output register is
// loaded; in_tready is low from acceptance until that load. The
// output register lets the next word be accepted while a result waits; a
// result that is not taken holds the following word in its last cycle.
// count_limit sits at byte address 0 of the apb port; writes of 0 or above
// 9999 store 9999, and a write never changes the counter.
`include "bcd_up_down_digit_counter_defines.svh"

module bcd_up_down_digit_counter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // direction[0], digit_position[2:1], amount[6:3], zero[7]
  input  logic        in_tuser,   // operation[0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // units_digit[3:0], tens_digit[7:4],
                                  // hundreds_digit[11:8], thousands_digit[15:12],
                                  // count_value[31:16], over_limit[32],
                                  // over_capacity[33], below_zero[34], zero[39:35]
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bcdc_pkg::*;

  // control
  bcdc_fsm_t   state_r, state_nxt;
  logic [3:0]  rem_r, rem_nxt;          // unit steps still to apply
  logic [1:0]  pos_r, pos_nxt;
  logic        sub_r, sub_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;

  // counter state and the shared step unit
  bcdc_ctr_t   ctr_r, ctr_nxt, ctr_step;
  logic [39:0] out_data_r;
  logic [13:0] limit_r;

  // word fields
  logic        in_op;
  logic        in_dir;
  logic [1:0]  in_pos;
  logic [3:0]  in_amount;
  logic        in_fire;

  // result flags
  logic        flag_over_limit;
  logic        flag_over_cap;
  logic        flag_below;

  // config write
  logic        cfg_write;
  logic [13:0] cfg_limit_val;

  assign in_op     = in_tuser;
  assign in_dir    = in_tdata[0];
  assign in_pos    = in_tdata[2:1];
  assign in_amount = in_tdata[6:3];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  bcdc_step u_step (
    .cur      (ctr_r),
    .pos      (pos_r),
    .subtract (sub_r),
    .nxt      (ctr_step)
  );

  // sequencer: accept, run the step unit rem times, then hand off to output
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    sub_nxt       = sub_r;
    ctr_nxt       = ctr_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt   = in_pos;
          sub_nxt   = in_dir;
          state_nxt = S_STEP;
          if (in_op == OP_CLEAR) begin
            ctr_nxt = '0;
            rem_nxt = 4'd0;
          end else begin
            rem_nxt = in_amount;
          end
        end
      end
      S_STEP: begin
        if (rem_r != 4'd0) begin
          ctr_nxt = ctr_step;
          rem_nxt = rem_r - 4'd1;
        end else if (!out_valid_r || out_tready) begin
          // output slot is free or being emptied this cycle
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rem_r       <= 4'd0;
      out_valid_r <= 1'b0;
      ctr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      ctr_r       <= ctr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    sub_r <= sub_nxt;
  end

  // flags come from the finished counter state
  assign flag_over_limit = ctr_r.count > $signed({2'b00, limit_r});
  assign flag_over_cap   = ctr_r.count > CAPACITY_MAX;
  assign flag_below      = ctr_r.count[15];

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'd0, flag_below, flag_over_cap, flag_over_limit,
                     ctr_r.count, ctr_r.digit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration port, no wait states
  assign cfg_pready    = 1'b1;
  assign cfg_write     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_limit_val = cfg_pwdata[13:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_write && cfg_paddr[2] == REG_COUNT_LIMIT) begin
      if (cfg_limit_val == 14'd0 || cfg_limit_val > LIMIT_RESET) begin
        limit_r <= LIMIT_RESET;
      end else begin
        limit_r <= cfg_limit_val;
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_COUNT_LIMIT) ? {18'd0, limit_r} : 32'd0;

  // checks
  `BCDC_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_tready, "accepted word did not make block busy")
  `BCDC_ASSERT_NOW(a_idle_no_steps, state_r == S_IDLE, rem_r == 4'd0, "steps pending while idle")
  `BCDC_ASSERT_NOW(a_limit_range, 1'b1, limit_r != 14'd0 && limit_r <= LIMIT_RESET, "count_limit out of range")
  `BCDC_ASSERT_NOW(a_bcd_digits, 1'b1, ctr_r.digit[0] <= 4'd9 && ctr_r.digit[1] <= 4'd9 && ctr_r.digit[2] <= 4'd9, "low digit left bcd range")

endmodule

// ===== src/bcdc_step.sv =====
module bcdc_step (
  input  bcdc_pkg::bcdc_ctr_t cur,
  input  logic [1:0]          pos,
  input  logic                subtract,
  output bcdc_pkg::bcdc_ctr_t nxt
);
  import bcdc_pkg::*;

  logic signed [16:0] delta;
  logic signed [16:0] sum;
  logic signed [15:0] cnt_sat;
  logic [3:0]         chain;

  // one unit step: saturating count update, then digit carry or borrow
  always_comb begin
    delta = {7'd0, weight_of(pos)};
    if (subtract) begin
      delta = -delta;
    end
    sum = {cur.count[15], cur.count} + delta;
    unique case (sum[16:15])
      2'b01:   cnt_sat = 16'sh7fff;
      2'b10:   cnt_sat = 16'sh8000;
      default: cnt_sat = sum[15:0];
    endcase

    nxt       = cur;
    nxt.count = cnt_sat;
    chain     = 4'd0;

    if (!subtract) begin
      if (pos == POS_THOUSANDS) begin
        if (cnt_sat <= CAPACITY_MAX) begin
          nxt.digit[3] = cur.digit[3] + 4'd1;
        end
      end else begin
        // carry ripples up from the chosen digit
        for (int i = 0; i < 3; i++) begin
          chain[i] = (pos == 2'(i)) || (i != 0 && chain[i-1] && pos < 2'(i));
          if (chain[i]) begin
            nxt.digit[i] = (cur.digit[i] >= 4'd9) ? 4'd0 : cur.digit[i] + 4'd1;
          end
          chain[i] = chain[i] && (cur.digit[i] >= 4'd9);
        end
        if (chain[2]) begin
          nxt.digit[3] = cur.digit[3] + 4'd1;
        end
      end
    end else if (!cnt_sat[15]) begin
      // borrow ripples up; a position above the chosen one borrows only when the digit below it wrapped
      for (int i = 0; i < 3; i++) begin
        chain[i] = (pos == 2'(i)) || (pos < 2'(i) && (i == 0 || chain[i-1]));
        if (chain[i]) begin
          nxt.digit[i] = (cur.digit[i] == 4'd0) ? 4'd9 : cur.digit[i] - 4'd1;
        end
        chain[i] = chain[i] && (cur.digit[i] == 4'd0);
      end
      chain[3] = (pos == POS_THOUSANDS) || chain[2];
      if (chain[3]) begin
        nxt.digit[3] = cur.digit[3] - 4'd1;
      end
    end
  end

endmodule

// ===== bench/tb_bcd_up_down_digit_counter.sv =====
module tb_bcd_up_down_digit_counter;
  import bcdc_pkg::*;

  // count saturation bounds and run limits
  localparam int COUNT_HI    = 32767;
  localparam int COUNT_LO    = -32768;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SEG_WORDS   = 300;
  localparam int SEG_COUNT   = 6;

  // one predicted output word, one field per member
  typedef struct {
    int units;
    int tens;
    int hundreds;
    int thousands;
    int count;
    int over_lim;
    int over_cap;
    int neg;
  } reading_t;

  // predictor of the counter plus the queue of readings still to come out
  class counter_model;
    int units, tens, hundreds, thousands;
    int count;
    int limit;
    int errors;
    reading_t readings[$];

    function new();
      units = 0; tens = 0; hundreds = 0; thousands = 0;
      count = 0;
      limit = int'(LIMIT_RESET);
      errors = 0;
    endfunction

    function void set_limit(logic [2:0] addr, logic [31:0] data);
      int v;
      v = int'(data[13:0]);
      if (addr[2] == REG_COUNT_LIMIT)
        limit = (v == 0 || v > int'(CAPACITY_MAX)) ? int'(LIMIT_RESET) : v;
    endfunction

    function int clamp(int v);
      if (v > COUNT_HI) return COUNT_HI;
      if (v < COUNT_LO) return COUNT_LO;
      return v;
    endfunction

    // increment at units, tens or hundreds with carry upward
    function void carry_up(logic [1:0] pos);
      if (pos == POS_UNITS) begin
        units++;
        if (units > 9) begin
          units -= 10;
          tens++;
        end
      end
      if (pos <= POS_TENS) begin
        if (pos == POS_TENS) tens++;
        if (tens > 9) begin
          tens -= 10;
          hundreds++;
        end
      end
      if (pos == POS_HUNDREDS) hundreds++;
      if (hundreds > 9) begin
        hundreds -= 10;
        thousands = (thousands + 1) & 15;
      end
    endfunction

    // decrement at any position with borrow upward
    function void borrow_down(logic [1:0] pos);
      bit borrow;
      borrow = 1'b1;
      if (pos == POS_UNITS) begin
        borrow = (units == 0);
        units = borrow ? 9 : units - 1;
      end
      if (pos <= POS_TENS && borrow) begin
        borrow = (tens == 0);
        tens = borrow ? 9 : tens - 1;
      end
      if (pos <= POS_HUNDREDS && borrow) begin
        borrow = (hundreds == 0);
        hundreds = borrow ? 9 : hundreds - 1;
      end
      if (borrow) thousands = (thousands - 1) & 15;
    endfunction

    function void unit_step(logic [1:0] pos, logic dir);
      int w;
      case (pos)
        POS_UNITS:    w = 1;
        POS_TENS:     w = 10;
        POS_HUNDREDS: w = 100;
        default:      w = 1000;
      endcase
      if (!dir) begin
        count = clamp(count + w);
        if (pos == POS_THOUSANDS) begin
          if (count <= int'(CAPACITY_MAX)) thousands = (thousands + 1) & 15;
        end else begin
          carry_up(pos);
        end
      end else begin
        count = clamp(count - w);
        if (count >= 0) borrow_down(pos);
      end
    endfunction

    // an input word was accepted: advance the state and queue its reading
    function void note_word(logic op, logic dir, logic [1:0] pos, logic [3:0] amt);
      reading_t r;
      if (op == OP_CLEAR) begin
        units = 0; tens = 0; hundreds = 0; thousands = 0;
        count = 0;
      end else begin
        for (int i = 0; i < int'(amt); i++) unit_step(pos, dir);
      end
      r.units = units;
      r.tens = tens;
      r.hundreds = hundreds;
      r.thousands = thousands;
      r.count = count;
      r.over_lim = int'(count > limit);
      r.over_cap = int'(count > int'(CAPACITY_MAX));
      r.neg = int'(count < 0);
      readings.push_back(r);
    endfunction

    function void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    // an output word was accepted: compare it with the oldest reading
    function void check_reading(logic [39:0] d);
      reading_t r;
      if (readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, expected none, actual %h", $time, d);
        return;
      end
      r = readings.pop_front();
      check_field("units_digit", r.units, int'(d[3:0]));
      check_field("tens_digit", r.tens, int'(d[7:4]));
      check_field("hundreds_digit", r.hundreds, int'(d[11:8]));
      check_field("thousands_digit", r.thousands, int'(d[15:12]));
      check_field("count_value", r.count, int'($signed(d[31:16])));
      check_field("over_limit", r.over_lim, int'(d[32]));
      check_field("over_capacity", r.over_cap, int'(d[33]));
      check_field("below_zero", r.neg, int'(d[34]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // direction[0], digit_position[2:1], amount[6:3], zero[7]
  logic        in_tuser;   // operation[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // units[3:0], tens[7:4], hundreds[11:8], thousands[15:12],
                           // count[31:16], over_limit[32], over_capacity[33],
                           // below_zero[34], zero[39:35]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  counter_model model = new();

  // idle percentages for each side, set per phase by the main sequence
  int send_idle = 0;
  int recv_idle = 0;
  // long receiver hold-off: requested by the main sequence, counted below
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_count = 0;

  bcd_up_down_digit_counter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 unit clock period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted words, then pick the next ready level;
  // a pending hold request stalls the receiver for a long stretch so the
  // block's output register and step unit fill and in_tready drops
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_reading(out_tdata);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog: too many cycles without any word moving ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one input word, idling first at random, and wait for acceptance
  task automatic send_word(logic op, logic dir, logic [1:0] pos, logic [3:0] amt);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, amt, pos, dir};
    do @(posedge clk); while (!in_tready);
    model.note_word(op, dir, pos, amt);
  endtask

  // random step or clear; up_pct biases the walk of the count
  task automatic send_random(int up_pct);
    logic       op;
    logic       dir;
    logic [1:0] pos;
    logic [3:0] amt;
    op = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_STEP;
    dir = ($urandom_range(0, 99) >= up_pct);
    pos = 2'($urandom_range(0, 3));
    // mostly legal amounts, some zero and above nine
    amt = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 9))
                                       : 4'($urandom_range(0, 15));
    send_word(op, dir, pos, amt);
  endtask

  // stop offering and wait until every reading has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (model.readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    model.set_limit(addr, data);
  endtask

  initial begin
    int up_pct;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_STEP;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset limit
    send_word(OP_CLEAR, 1'b0, POS_UNITS, 4'd0);
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd15);       // amount above nine
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd0);        // zero amount, no change
    send_word(OP_STEP, 1'b0, POS_TENS, 4'd15);
    send_word(OP_STEP, 1'b0, POS_HUNDREDS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_THOUSANDS, 4'd9);    // passes 9999
    send_word(OP_STEP, 1'b0, POS_THOUSANDS, 4'd15);   // climbs toward the high saturation bound
    send_word(OP_STEP, 1'b0, POS_THOUSANDS, 4'd15);
    // walk down through zero to the low saturation bound
    repeat (5) send_word(OP_STEP, 1'b1, POS_THOUSANDS, 4'd15);
    send_word(OP_CLEAR, 1'b1, POS_THOUSANDS, 4'd15);  // clear ignores other fields
    // build 9999, then carry into the thousands digit past nine
    send_word(OP_STEP, 1'b0, POS_THOUSANDS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_HUNDREDS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_TENS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd9);
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd1);
    send_word(OP_STEP, 1'b1, POS_UNITS, 4'd3);        // borrow chain
    send_word(OP_CLEAR, 1'b0, POS_UNITS, 4'd1);
    send_word(OP_STEP, 1'b1, POS_UNITS, 4'd1);        // below zero, digits hold
    send_word(OP_STEP, 1'b0, POS_UNITS, 4'd2);
    // digits lag the count; the count goes below zero, so no digit borrows
    send_word(OP_STEP, 1'b1, POS_THOUSANDS, 4'd15);
    drain();

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      // idle profile: sender light / receiver heavy, then swapped, then none
      case (seg / 2)
        0: begin send_idle = 14; recv_idle = 46; end
        1: begin send_idle = 46; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      // limit settings across the range, out-of-range values fall back to 9999
      case (seg)
        0: cfg_write(3'd0, 32'd1);
        1: begin
          cfg_write(3'd0, 32'd0);
          cfg_write(3'd0, 32'd10000);
        end
        2: begin
          cfg_write(3'd0, 32'h0001_0005);               // upper bits dropped
          cfg_write(3'd4, $urandom());                   // unknown register, ignored
        end
        3: cfg_write(3'd0, 32'd16383);
        4: cfg_write(3'd0, $urandom_range(1, 9999));
        default: cfg_write(3'd0, 32'd9999);
      endcase
      // long receiver hold-off while the sender keeps offering
      if (seg == 4) hold_req <= 1'b1;
      up_pct = 50;
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (n % 50 == 0) begin
          case ($urandom_range(0, 2))
            0: up_pct = 20;
            1: up_pct = 50;
            default: up_pct = 80;
          endcase
        end
        send_random(up_pct);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (model.errors == 0 && model.readings.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
